// File: rtl/mips32_pkg.sv
// mips32_pkg: shared types, opcodes and constants for the MIPS-I integer core.
// No dependencies; imported by the datapath, the controller and the top module of the core.
package mips32_pkg;

    localparam int unsigned DMEM_BYTES_DEF = 4096;
    localparam int unsigned IN_W           = 80;
    localparam int unsigned OUT_W          = 184;
    localparam int unsigned MADDR_W        = 12;

    localparam logic [31:0] START_PC_RST = 32'h0040_0000;
    localparam logic [31:0] PC_HI_MASK   = 32'hf000_0000;
    localparam logic [31:0] JT_MASK      = 32'h0fff_fffc;
    localparam logic [31:0] EXIT_CODE    = 32'd10;
    localparam logic [4:0]  LINK_REG     = 5'd31;
    localparam logic [4:0]  V0_REG       = 5'd2;
    localparam logic [5:0]  OP_SHIFT     = 6'd26;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    // REGIMM selectors
    localparam logic [4:0] RI_BLTZ    = 5'h00;
    localparam logic [4:0] RI_BGEZ    = 5'h01;
    localparam logic [4:0] RI_BLTZAL  = 5'h10;
    localparam logic [4:0] RI_BGEZAL  = 5'h11;

    typedef enum logic [1:0] {
        KIND_ALU,
        KIND_LOAD,
        KIND_STORE,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        logic clr;
        logic capture;
        logic rd_rs;
        logic rd_rt;
        logic lat_rt;
        logic exec;
        logic mwr;
        logic mrd;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic  preload;
        logic  halted;
        kind_t kind;
        logic  wr_last;
        logic  rd_last;
        logic  clr_last;
        logic  div_done;
    } ctrl_stat_t;

endpackage

// File: rtl/mips32_ram.sv
// mips32_ram: generic RAM, one write port and one read port, registered read.
// No dependencies.
module mips32_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/mips32_div.sv
// mips32_div: iterative restoring divider, one quotient bit per cycle.
// Signed results truncate toward zero. Depends on nothing.
module mips32_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        sgn,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] quo,
    output logic [31:0] rem
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] q_reg;
    logic [31:0] r_reg;
    logic [31:0] d_reg;
    logic        negq_reg;
    logic        negr_reg;
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial = {r_reg, q_reg[31]};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= (sgn && a[31]) ? (32'd0 - a) : a;
            d_reg    <= (sgn && b[31]) ? (32'd0 - b) : b;
            r_reg    <= '0;
            negq_reg <= sgn & (a[31] ^ b[31]);
            negr_reg <= sgn & a[31];
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                r_reg <= diff[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = negq_reg ? (32'd0 - q_reg) : q_reg;
    assign rem  = negr_reg ? (32'd0 - r_reg) : r_reg;

    assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
        else $error("divide started while busy");
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divide done while still iterating");
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == 5'd31) |=> done_reg)
        else $error("divide did not finish after last step");

endmodule

// File: rtl/mips32_dp.sv
// mips32_dp: datapath - PC, HI/LO, halt flag, register file and byte data memory,
// decode/execute and the result register. Depends on mips32_pkg, mips32_ram, mips32_div.
module mips32_dp #(
    parameter int unsigned DMEM_BYTES = mips32_pkg::DMEM_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [mips32_pkg::IN_W-1:0]  in_data,
    input  logic                         in_type,
    input  logic                         cfg_we,
    input  logic [31:0]                  cfg_data,
    input  mips32_pkg::ctrl_cmd_t        cmd,
    output mips32_pkg::ctrl_stat_t       st,
    output logic [mips32_pkg::OUT_W-1:0] out_data
);
    import mips32_pkg::*;

    localparam int unsigned AW    = $clog2(DMEM_BYTES);
    localparam int unsigned CLR_N = (DMEM_BYTES > 32) ? DMEM_BYTES : 32;
    localparam int unsigned CW    = $clog2(CLR_N);

    typedef enum logic [2:0] {HL_NONE, HL_MTHI, HL_MTLO, HL_MUL, HL_DIV} hl_t;
    typedef enum logic [2:0] {LD_NONE, LD_B, LD_H, LD_W, LD_BU, LD_HU} ld_t;

    // architectural state
    logic [31:0]   pc_reg;
    logic [31:0]   hi_reg;
    logic [31:0]   lo_reg;
    logic          halt_reg;
    logic [CW-1:0] clr_cnt_reg;
    logic [2:0]    cnt_reg;

    // per-item working registers
    logic          preload_reg;
    logic [31:0]   ins_reg;
    logic [31:0]   rs_reg;
    logic [31:0]   rt_reg;
    logic [AW-1:0] ea_reg;
    logic [31:0]   wdata_reg;
    logic [1:0]    nbm1_reg;
    logic [31:0]   rword_reg;
    logic          rw_reg;
    logic [4:0]    ri_reg;
    logic [31:0]   rv_reg;
    logic [31:0]   npc_reg;
    hl_t           hl_reg;
    ld_t           ld_reg;
    logic          sys_reg;
    logic          mw_reg;
    logic [63:0]   prod_reg;
    logic [OUT_W-1:0] out_reg;

    // decode fields
    logic [5:0]  op;
    logic [4:0]  rsf;
    logic [4:0]  rtf;
    logic [4:0]  rdf;
    logic [4:0]  sh;
    logic [5:0]  fn;
    logic [31:0] imm;
    logic [31:0] simm;
    logic [31:0] pc4;
    logic [31:0] btgt;
    logic [31:0] jtgt;
    logic [31:0] ea_full;
    logic        lez;

    assign op      = ins_reg[31:26];
    assign rsf     = ins_reg[25:21];
    assign rtf     = ins_reg[20:16];
    assign rdf     = ins_reg[15:11];
    assign sh      = ins_reg[10:6];
    assign fn      = ins_reg[5:0];
    assign imm     = {16'd0, ins_reg[15:0]};
    assign simm    = {{16{ins_reg[15]}}, ins_reg[15:0]};
    assign pc4     = pc_reg + 32'd4;
    assign btgt    = pc_reg + {simm[29:0], 2'b00};
    assign jtgt    = (pc_reg & PC_HI_MASK) + ({ins_reg[29:0], 2'b00} & JT_MASK);
    assign ea_full = rs_reg + simm;
    assign lez     = (rs_reg == 32'd0) || rs_reg[31];

    // execute results
    logic        ex_wv;
    logic [4:0]  ex_widx;
    logic [31:0] ex_wval;
    logic [31:0] ex_npc;
    hl_t         ex_hl;
    ld_t         ex_ld;
    logic        ex_store;
    logic [1:0]  ex_nbm1;
    logic        ex_div;
    logic        ex_sys;
    logic        ex_msgn;
    logic signed [65:0] ex_prod;

    always_comb
    begin
        ex_wv    = 1'b0;
        ex_widx  = rtf;
        ex_wval  = '0;
        ex_npc   = pc4;
        ex_hl    = HL_NONE;
        ex_ld    = LD_NONE;
        ex_store = 1'b0;
        ex_nbm1  = 2'd3;
        ex_div   = 1'b0;
        ex_sys   = 1'b0;
        unique case (op)
            OP_SPECIAL:
            begin
                ex_widx = rdf;
                unique case (fn)
                    FN_SLL:  begin ex_wv = 1'b1; ex_wval = rt_reg << sh; end
                    FN_SRL:  begin ex_wv = 1'b1; ex_wval = rt_reg >> sh; end
                    FN_SRA:  begin ex_wv = 1'b1; ex_wval = 32'($signed(rt_reg) >>> sh); end
                    FN_SLLV: begin ex_wv = 1'b1; ex_wval = rt_reg << rs_reg[4:0]; end
                    FN_SRLV: begin ex_wv = 1'b1; ex_wval = rt_reg >> rs_reg[4:0]; end
                    FN_SRAV:
                    begin
                        ex_wv   = 1'b1;
                        ex_wval = 32'($signed(rt_reg) >>> rs_reg[4:0]);
                    end
                    FN_JR:   ex_npc = rs_reg;
                    FN_JALR: begin ex_npc = rs_reg; ex_wv = 1'b1; ex_wval = pc4; end
                    FN_SYSCALL: ex_sys = (rt_reg == EXIT_CODE);
                    FN_MFHI: begin ex_wv = 1'b1; ex_wval = hi_reg; end
                    FN_MTHI: ex_hl = HL_MTHI;
                    FN_MFLO: begin ex_wv = 1'b1; ex_wval = lo_reg; end
                    FN_MTLO: ex_hl = HL_MTLO;
                    FN_MULT, FN_MULTU: ex_hl = HL_MUL;
                    FN_DIV, FN_DIVU:
                    begin
                        if (rt_reg != 32'd0)
                        begin
                            ex_div = 1'b1;
                            ex_hl  = HL_DIV;
                        end
                    end
                    FN_ADD, FN_ADDU: begin ex_wv = 1'b1; ex_wval = rs_reg + rt_reg; end
                    FN_SUB, FN_SUBU: begin ex_wv = 1'b1; ex_wval = rs_reg - rt_reg; end
                    FN_AND:  begin ex_wv = 1'b1; ex_wval = rs_reg & rt_reg; end
                    FN_OR:   begin ex_wv = 1'b1; ex_wval = rs_reg | rt_reg; end
                    FN_XOR:  begin ex_wv = 1'b1; ex_wval = rs_reg ^ rt_reg; end
                    FN_NOR:  begin ex_wv = 1'b1; ex_wval = ~(rs_reg | rt_reg); end
                    FN_SLT:
                    begin
                        ex_wv   = 1'b1;
                        ex_wval = {31'd0, $signed(rs_reg) < $signed(rt_reg)};
                    end
                    FN_SLTU: begin ex_wv = 1'b1; ex_wval = {31'd0, rs_reg < rt_reg}; end
                    default: ;
                endcase
            end
            OP_REGIMM:
            begin
                ex_widx = LINK_REG;
                ex_wval = pc4;
                unique case (rtf)
                    RI_BLTZ: if (rs_reg[31]) ex_npc = btgt;
                    RI_BGEZ: if (!rs_reg[31]) ex_npc = btgt;
                    RI_BLTZAL:
                    begin
                        ex_wv = 1'b1;
                        if (rs_reg[31]) ex_npc = btgt;
                    end
                    RI_BGEZAL:
                    begin
                        ex_wv = 1'b1;
                        if (!rs_reg[31]) ex_npc = btgt;
                    end
                    default: ;
                endcase
            end
            OP_J:    ex_npc = jtgt;
            OP_JAL:  begin ex_npc = jtgt; ex_wv = 1'b1; ex_widx = LINK_REG; ex_wval = pc4; end
            OP_BEQ:  if (rs_reg == rt_reg) ex_npc = btgt;
            OP_BNE:  if (rs_reg != rt_reg) ex_npc = btgt;
            OP_BLEZ: if (lez) ex_npc = btgt;
            OP_BGTZ: if (!lez) ex_npc = btgt;
            OP_ADDI, OP_ADDIU: begin ex_wv = 1'b1; ex_wval = rs_reg + simm; end
            OP_SLTI:
            begin
                ex_wv   = 1'b1;
                ex_wval = {31'd0, $signed(rs_reg) < $signed(simm)};
            end
            OP_SLTIU: begin ex_wv = 1'b1; ex_wval = {31'd0, rs_reg < simm}; end
            OP_ANDI:  begin ex_wv = 1'b1; ex_wval = rs_reg & imm; end
            OP_ORI:   begin ex_wv = 1'b1; ex_wval = rs_reg | imm; end
            OP_XORI:  begin ex_wv = 1'b1; ex_wval = rs_reg ^ imm; end
            OP_LUI:   begin ex_wv = 1'b1; ex_wval = {ins_reg[15:0], 16'd0}; end
            OP_LB:    begin ex_wv = 1'b1; ex_ld = LD_B; end
            OP_LH:    begin ex_wv = 1'b1; ex_ld = LD_H; end
            OP_LW:    begin ex_wv = 1'b1; ex_ld = LD_W; end
            OP_LBU:   begin ex_wv = 1'b1; ex_ld = LD_BU; end
            OP_LHU:   begin ex_wv = 1'b1; ex_ld = LD_HU; end
            OP_SB:    begin ex_store = 1'b1; ex_nbm1 = 2'd0; end
            OP_SH:    begin ex_store = 1'b1; ex_nbm1 = 2'd1; end
            OP_SW:    begin ex_store = 1'b1; ex_nbm1 = 2'd3; end
            default: ;
        endcase
    end

    assign ex_msgn = (fn == FN_MULT);
    assign ex_prod = $signed({ex_msgn & rs_reg[31], rs_reg})
                   * $signed({ex_msgn & rt_reg[31], rt_reg});

    // divider
    logic        div_done;
    logic [31:0] div_q;
    logic [31:0] div_r;

    mips32_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.exec && ex_div),
        .sgn   (fn == FN_DIV),
        .a     (rs_reg),
        .b     (rt_reg),
        .done  (div_done),
        .quo   (div_q),
        .rem   (div_r)
    );

    // register file
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic [4:0]  rf_raddr;
    logic [31:0] rf_rdata;
    logic [31:0] rv_fin;

    function automatic logic [4:0] in_rs_sel();
        return ins_reg[25:21];
    endfunction

    function automatic logic [4:0] in_rt_sel();
        return (ins_reg[31:26] == OP_SPECIAL && ins_reg[5:0] == FN_SYSCALL)
               ? V0_REG : ins_reg[20:16];
    endfunction

    assign rf_we    = (cmd.clr && (int'(clr_cnt_reg) < 32)) || (cmd.commit && rw_reg);
    assign rf_waddr = cmd.clr ? clr_cnt_reg[4:0] : ri_reg;
    assign rf_wdata = cmd.clr ? 32'd0 : rv_fin;
    // SYSCALL only needs $v0 for the exit test
    assign rf_raddr = cmd.rd_rs ? in_rs_sel() : in_rt_sel();

    mips32_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    // data memory, one byte per cycle
    logic          dm_we;
    logic [AW-1:0] dm_waddr;
    logic [7:0]    dm_wdata;
    logic [AW-1:0] dm_raddr;
    logic [7:0]    dm_rdata;
    logic [1:0]    cnt_m1;

    assign dm_we    = (cmd.clr && (int'(clr_cnt_reg) < int'(DMEM_BYTES))) || cmd.mwr;
    assign dm_waddr = cmd.clr ? clr_cnt_reg[AW-1:0] : ea_reg + AW'(cnt_reg[1:0]);
    assign dm_wdata = cmd.clr ? 8'd0 : wdata_reg[{cnt_reg[1:0], 3'b000} +: 8];
    assign dm_raddr = ea_reg + AW'(cnt_reg[1:0]);
    assign cnt_m1   = 2'(cnt_reg - 3'd1);

    mips32_ram #(.WIDTH(8), .DEPTH(DMEM_BYTES)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .raddr (dm_raddr),
        .rdata (dm_rdata)
    );

    // status to controller
    always_comb
    begin
        st.preload  = preload_reg;
        st.halted   = halt_reg;
        st.wr_last  = (cnt_reg == {1'b0, nbm1_reg});
        st.rd_last  = (cnt_reg == 3'd4);
        st.clr_last = (clr_cnt_reg == CW'(CLR_N - 1));
        st.div_done = div_done;
        if (ex_ld != LD_NONE)
            st.kind = KIND_LOAD;
        else if (ex_store)
            st.kind = KIND_STORE;
        else if (ex_div)
            st.kind = KIND_DIV;
        else
            st.kind = KIND_ALU;
    end

    // commit values
    logic [31:0] hi_n;
    logic [31:0] lo_n;
    logic        halt_n;
    logic [31:0] rv_out;
    logic [31:0] md_out;

    always_comb
    begin
        unique case (ld_reg)
            LD_B:    rv_fin = {{24{rword_reg[7]}}, rword_reg[7:0]};
            LD_H:    rv_fin = {{16{rword_reg[15]}}, rword_reg[15:0]};
            LD_W:    rv_fin = rword_reg;
            LD_BU:   rv_fin = {24'd0, rword_reg[7:0]};
            LD_HU:   rv_fin = {16'd0, rword_reg[15:0]};
            default: rv_fin = rv_reg;
        endcase
        hi_n = hi_reg;
        lo_n = lo_reg;
        unique case (hl_reg)
            HL_MTHI: hi_n = rs_reg;
            HL_MTLO: lo_n = rs_reg;
            HL_MUL:  begin hi_n = prod_reg[63:32]; lo_n = prod_reg[31:0]; end
            HL_DIV:  begin hi_n = div_r; lo_n = div_q; end
            default: ;
        endcase
    end

    assign halt_n = halt_reg | sys_reg;
    assign rv_out = rw_reg ? rv_fin : 32'd0;
    assign md_out = mw_reg ? rword_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= START_PC_RST;
            hi_reg      <= '0;
            lo_reg      <= '0;
            halt_reg    <= 1'b0;
            clr_cnt_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.clr)
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            if (cmd.capture || (cmd.mwr && st.wr_last))
                cnt_reg <= '0;
            else if (cmd.mwr || cmd.mrd)
                cnt_reg <= cnt_reg + 3'd1;
            if (cfg_we)
                pc_reg <= cfg_data;
            else if (cmd.commit)
                pc_reg <= npc_reg;
            if (cmd.commit)
            begin
                hi_reg   <= hi_n;
                lo_reg   <= lo_n;
                halt_reg <= halt_n;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            preload_reg <= in_type;
            ins_reg     <= in_data[31:0];
            ea_reg      <= AW'(in_data[43:32]);
            wdata_reg   <= in_data[75:44];
            nbm1_reg    <= 2'd3;
            rw_reg      <= 1'b0;
            ri_reg      <= '0;
            rv_reg      <= '0;
            npc_reg     <= pc_reg;
            hl_reg      <= HL_NONE;
            ld_reg      <= LD_NONE;
            sys_reg     <= 1'b0;
            mw_reg      <= in_type;
        end
        if (cmd.rd_rt)
            rs_reg <= rf_rdata;
        if (cmd.lat_rt)
            rt_reg <= rf_rdata;
        if (cmd.exec)
        begin
            rw_reg   <= ex_wv && (ex_widx != 5'd0);
            ri_reg   <= (ex_wv && ex_widx != 5'd0) ? ex_widx : 5'd0;
            rv_reg   <= ex_wval;
            npc_reg  <= ex_npc;
            hl_reg   <= ex_hl;
            ld_reg   <= ex_ld;
            sys_reg  <= ex_sys;
            prod_reg <= ex_prod[63:0];
            if (ex_store)
            begin
                mw_reg    <= 1'b1;
                ea_reg    <= ea_full[AW-1:0];
                wdata_reg <= rt_reg;
                nbm1_reg  <= ex_nbm1;
            end
            else if (ex_ld != LD_NONE)
            begin
                ea_reg <= ea_full[AW-1:0];
            end
        end
        if (cmd.mrd && cnt_reg != 3'd0)
            rword_reg[{cnt_m1, 3'b000} +: 8] <= dm_rdata;
        if (cmd.commit)
            out_reg <= {4'd0, md_out, MADDR_W'(ea_reg & {AW{mw_reg}}), mw_reg,
                        lo_n, hi_n, rv_out, ri_reg, rw_reg, halt_n, npc_reg};
    end

    assign out_data = out_reg;

endmodule

// File: rtl/mips32_ctrl.sv
// mips32_ctrl: controller state machine sequencing memory clear, operand reads,
// execute, byte-wise memory access, divide wait and result handoff. Uses mips32_pkg.
module mips32_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  mips32_pkg::ctrl_stat_t st,
    output mips32_pkg::ctrl_cmd_t  cmd
);
    import mips32_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RRS, S_RRT, S_LAT, S_EX, S_MWR, S_MRD, S_DIV, S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.clr     = (state_reg == S_CLR);
        cmd.capture = accept;
        cmd.rd_rs   = (state_reg == S_RRS);
        cmd.rd_rt   = (state_reg == S_RRT);
        cmd.lat_rt  = (state_reg == S_LAT);
        cmd.exec    = (state_reg == S_EX);
        cmd.mwr     = (state_reg == S_MWR);
        cmd.mrd     = (state_reg == S_MRD);
        cmd.commit  = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (st.clr_last) state_next = S_IDLE;
            S_IDLE: if (s_tvalid) state_next = S_RRS;
            S_RRS:
            begin
                priority if (st.preload) state_next = S_MWR;
                else if (st.halted)      state_next = S_FIN;
                else                     state_next = S_RRT;
            end
            S_RRT:  state_next = S_LAT;
            S_LAT:  state_next = S_EX;
            S_EX:
            begin
                unique case (st.kind)
                    KIND_LOAD:  state_next = S_MRD;
                    KIND_STORE: state_next = S_MWR;
                    KIND_DIV:   state_next = S_DIV;
                    default:    state_next = S_FIN;
                endcase
            end
            S_MWR:  if (st.wr_last) state_next = S_MRD;
            S_MRD:  if (st.rd_last) state_next = S_FIN;
            S_DIV:  if (st.div_done) state_next = S_FIN;
            S_FIN:  if (cmd.commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.commit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) accept |=> state_reg == S_RRS)
        else $error("accepted request not dispatched");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && st.div_done) |=> state_reg == S_FIN)
        else $error("divide completion missed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && m_tvalid_reg && !m_tready) |=> state_reg == S_FIN)
        else $error("result overwrote a pending output");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid_reg)
        else $error("commit without output valid");

endmodule

// File: rtl/mips32_integer_core_step.sv
// mips32_integer_core_step: MIPS-I integer core, one instruction or preload per request.
// One request at a time; m_tvalid is set by commit. A halted core skips execute, a zero
// divisor skips the divider, and stores and preloads read their bytes back before commit;
// a held output delays commit, and s_tready rises again in the cycle after commit. Memory
// access uses the byte-wide memory port, and divides use the one-bit-per-cycle divider.
// Reset: memory and registers are cleared with s_tready low; PC 0x00400000.
module mips32_integer_core_step #(
    parameter int unsigned DMEM_BYTES = mips32_pkg::DMEM_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // instr[31:0], preload_addr[43:32], preload_data[75:44], zero pad
    input  logic [mips32_pkg::IN_W-1:0]  s_tdata,
    // req_type[0]
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // next_pc[31:0], halted[32], reg_written[33], reg_index[38:34], reg_value[70:39],
    // hi_value[102:71], lo_value[134:103], mem_written[135], wr_addr[147:136],
    // mem_data[179:148], zero pad
    output logic [mips32_pkg::OUT_W-1:0] m_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    // start_pc
    input  logic [31:0]                  cfg_data
);
    import mips32_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t st;

    assign cfg_ready = 1'b1;

    mips32_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    mips32_dp #(.DMEM_BYTES(DMEM_BYTES)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (s_tdata),
        .in_type  (s_tuser),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .st       (st),
        .out_data (m_tdata)
    );

endmodule
